// ===== sv/bffa_pkg.sv =====
package bffa_pkg;

  localparam int MAX_PAGES   = 8192;
  localparam int NUM_REGIONS = 2;
  localparam int MAX_EXTENTS = 64;

  localparam int PG_W   = $clog2(MAX_PAGES);
  localparam int CNT_W  = PG_W + 1;
  localparam int REG_W  = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int ADDR_W = REG_W + PG_W;
  localparam int PDEPTH = NUM_REGIONS * MAX_PAGES;
  localparam int EXT_AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int KW     = 7;
  localparam int EXT_W  = PG_W + CNT_W;
  localparam int OWN_W  = 8;
  localparam int CAP_W  = 7;
  localparam int CFG_W  = 14;
  localparam int CFG_IW = 1;

  localparam logic [CFG_W-1:0] PAGES_RST [2] = '{14'd8192, 14'd1024};

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_NOMEM   = 3'd2;
  localparam logic [2:0] ST_CAP     = 3'd3;
  localparam logic [2:0] ST_PERM    = 3'd4;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_FREE    = 2'd1;
  localparam logic [1:0] MODE_RECLAIM = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_PEND_PUSH, OP_SCAN_INIT, OP_PG_RD, OP_A_EV, OP_G_EV,
    OP_G_REC, OP_GRAM_RD, OP_C_LD, OP_PG_WR_OWN, OP_K_INC, OP_K_ZERO,
    OP_PRAM_RD, OP_F_LD, OP_F_PEV, OP_P_PEV, OP_R_EV, OP_R_INIT, OP_R_NEXT
  } op_e;

  typedef enum logic [1:0] {EC_ZERO, EC_ONE, EC_NEX, EC_BATCH} ec_sel_e;

  typedef struct packed {
    op_e        op;
    logic       idle;
    logic       out_ld;
    logic [2:0] out_st;
    ec_sel_e    ec_sel;
    logic       ext;
    logic       batch_clr;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       last_ext;
    logic       contig;
    logic       a_bad;
    logic       a_nomem;
    logic       own_zero;
    logic       found;
    logic       scan_end;
    logic       cap_zero;
    logic       rd_zero;
    logic       rd_own;
    logic       in_run;
    logic       g_done;
    logic       got_full;
    logic       nex_gt_cap;
    logic       idx_ge_total;
    logic       k_eq_pcnt;
    logic       f_bad;
    logic       len_one;
    logic       ext_last;
    logic       region_last;
    logic       berr;
    logic       clr_busy;
  } sts_t;

endpackage

// ===== sv/bffa_ram.sv =====
module bffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bffa_ctrl.sv =====
module bffa_ctrl import bffa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_ready_o,
  output logic out_valid_o
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_A_RD    = 5'd2;
  localparam logic [4:0] S_A_EV    = 5'd3;
  localparam logic [4:0] S_G_INIT  = 5'd4;
  localparam logic [4:0] S_G_RD    = 5'd5;
  localparam logic [4:0] S_G_EV    = 5'd6;
  localparam logic [4:0] S_G_REC   = 5'd7;
  localparam logic [4:0] S_G_END   = 5'd8;
  localparam logic [4:0] S_C_RD    = 5'd9;
  localparam logic [4:0] S_C_LD    = 5'd10;
  localparam logic [4:0] S_C_WR    = 5'd11;
  localparam logic [4:0] S_C_NEXT  = 5'd12;
  localparam logic [4:0] S_F_START = 5'd13;
  localparam logic [4:0] S_F_RD    = 5'd14;
  localparam logic [4:0] S_F_LD    = 5'd15;
  localparam logic [4:0] S_F_PRD   = 5'd16;
  localparam logic [4:0] S_F_PEV   = 5'd17;
  localparam logic [4:0] S_P_RD    = 5'd18;
  localparam logic [4:0] S_P_LD    = 5'd19;
  localparam logic [4:0] S_P_PRD   = 5'd20;
  localparam logic [4:0] S_P_PEV   = 5'd21;
  localparam logic [4:0] S_R_RD    = 5'd22;
  localparam logic [4:0] S_R_EV    = 5'd23;
  localparam logic [4:0] S_OUT     = 5'd24;

  logic [4:0] state_q, state_d, ret_q, ret_d;

  assign in_ready_o  = (state_q == S_IDLE) && !sts_i.clr_busy;
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    cmd_o      = '0;
    cmd_o.op   = OP_NONE;
    cmd_o.idle = (state_q == S_IDLE);
    state_d    = state_q;
    ret_d      = ret_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.mode)
          MODE_ALLOC: begin
            if (sts_i.a_bad) begin
              cmd_o.out_ld = 1'b1; cmd_o.out_st = ST_INVALID;
              state_d = S_OUT; ret_d = S_IDLE;
            end else if (sts_i.a_nomem) begin
              cmd_o.out_ld = 1'b1; cmd_o.out_st = ST_NOMEM;
              state_d = S_OUT; ret_d = S_IDLE;
            end else begin
              cmd_o.op = OP_SCAN_INIT;
              state_d  = S_A_RD;
            end
          end
          MODE_FREE: begin
            cmd_o.op = OP_PEND_PUSH;
            state_d  = sts_i.last_ext ? S_F_START : S_IDLE;
          end
          MODE_RECLAIM: begin
            if (sts_i.own_zero) begin
              cmd_o.out_ld = 1'b1; cmd_o.out_st = ST_INVALID;
              state_d = S_OUT; ret_d = S_IDLE;
            end else begin
              cmd_o.op = OP_R_INIT;
              state_d  = S_R_RD;
            end
          end
          default: begin
            cmd_o.out_ld = 1'b1; cmd_o.out_st = ST_INVALID;
            state_d = S_OUT; ret_d = S_IDLE;
          end
        endcase
      end
      S_A_RD: begin
        cmd_o.op = OP_PG_RD;
        state_d  = S_A_EV;
      end
      S_A_EV: begin
        if (sts_i.found && sts_i.cap_zero) begin
          cmd_o.out_ld = 1'b1; cmd_o.out_st = ST_CAP; cmd_o.ec_sel = EC_ONE;
          state_d = S_OUT; ret_d = S_IDLE;
        end else begin
          cmd_o.op = OP_A_EV;
          if (sts_i.found) begin
            state_d = S_C_WR;
          end else if (sts_i.scan_end) begin
            if (sts_i.contig) begin
              cmd_o.out_ld = 1'b1; cmd_o.out_st = ST_CAP;
              state_d = S_OUT; ret_d = S_IDLE;
            end else begin
              state_d = S_G_INIT;
            end
          end else begin
            state_d = S_A_RD;
          end
        end
      end
      S_G_INIT: begin
        cmd_o.op = OP_SCAN_INIT;
        state_d  = S_G_RD;
      end
      S_G_RD: begin
        if (sts_i.idx_ge_total) begin
          state_d = S_G_END;
        end else begin
          cmd_o.op = OP_PG_RD;
          state_d  = S_G_EV;
        end
      end
      S_G_EV: begin
        cmd_o.op = OP_G_EV;
        if (sts_i.rd_zero) begin
          state_d = sts_i.g_done ? S_G_REC : S_G_RD;
        end else begin
          state_d = sts_i.in_run ? S_G_REC : S_G_RD;
        end
      end
      S_G_REC: begin
        cmd_o.op = OP_G_REC;
        state_d  = sts_i.got_full ? S_G_END : S_G_RD;
      end
      S_G_END: begin
        if (!sts_i.got_full) begin
          cmd_o.out_ld = 1'b1; cmd_o.out_st = ST_NOMEM;
          state_d = S_OUT; ret_d = S_IDLE;
        end else if (sts_i.nex_gt_cap) begin
          cmd_o.out_ld = 1'b1; cmd_o.out_st = ST_CAP; cmd_o.ec_sel = EC_NEX;
          state_d = S_OUT; ret_d = S_IDLE;
        end else begin
          cmd_o.op = OP_K_ZERO;
          state_d  = S_C_RD;
        end
      end
      S_C_RD: begin
        cmd_o.op = OP_GRAM_RD;
        state_d  = S_C_LD;
      end
      S_C_LD: begin
        cmd_o.op = OP_C_LD;
        state_d  = S_C_WR;
      end
      S_C_WR: begin
        cmd_o.op = OP_PG_WR_OWN;
        if (sts_i.len_one) begin
          cmd_o.out_ld = 1'b1; cmd_o.out_st = ST_OK;
          cmd_o.ec_sel = EC_NEX; cmd_o.ext = 1'b1;
          state_d = S_OUT;
          ret_d   = sts_i.ext_last ? S_IDLE : S_C_NEXT;
        end
      end
      S_C_NEXT: begin
        cmd_o.op = OP_K_INC;
        state_d  = S_C_RD;
      end
      S_F_START: begin
        if (sts_i.berr || sts_i.own_zero) begin
          cmd_o.out_ld = 1'b1; cmd_o.out_st = ST_INVALID;
          cmd_o.ec_sel = EC_BATCH; cmd_o.batch_clr = 1'b1;
          state_d = S_OUT; ret_d = S_IDLE;
        end else begin
          cmd_o.op = OP_K_ZERO;
          state_d  = S_F_RD;
        end
      end
      S_F_RD: begin
        if (sts_i.k_eq_pcnt) begin
          cmd_o.op = OP_K_ZERO;
          state_d  = S_P_RD;
        end else begin
          cmd_o.op = OP_PRAM_RD;
          state_d  = S_F_LD;
        end
      end
      S_F_LD: begin
        if (sts_i.f_bad) begin
          cmd_o.out_ld = 1'b1; cmd_o.out_st = ST_INVALID;
          cmd_o.ec_sel = EC_BATCH; cmd_o.batch_clr = 1'b1;
          state_d = S_OUT; ret_d = S_IDLE;
        end else begin
          cmd_o.op = OP_F_LD;
          state_d  = S_F_PRD;
        end
      end
      S_F_PRD: begin
        cmd_o.op = OP_PG_RD;
        state_d  = S_F_PEV;
      end
      S_F_PEV: begin
        if (!sts_i.rd_own) begin
          cmd_o.out_ld = 1'b1; cmd_o.out_st = ST_PERM;
          cmd_o.ec_sel = EC_BATCH; cmd_o.batch_clr = 1'b1;
          state_d = S_OUT; ret_d = S_IDLE;
        end else begin
          cmd_o.op = OP_F_PEV;
          state_d  = sts_i.len_one ? S_F_RD : S_F_PRD;
        end
      end
      S_P_RD: begin
        if (sts_i.k_eq_pcnt) begin
          cmd_o.out_ld = 1'b1; cmd_o.out_st = ST_OK;
          cmd_o.ec_sel = EC_BATCH; cmd_o.batch_clr = 1'b1;
          state_d = S_OUT; ret_d = S_IDLE;
        end else begin
          cmd_o.op = OP_PRAM_RD;
          state_d  = S_P_LD;
        end
      end
      S_P_LD: begin
        cmd_o.op = OP_F_LD;
        state_d  = S_P_PRD;
      end
      S_P_PRD: begin
        cmd_o.op = OP_PG_RD;
        state_d  = S_P_PEV;
      end
      S_P_PEV: begin
        cmd_o.op = OP_P_PEV;
        state_d  = sts_i.len_one ? S_P_RD : S_P_PRD;
      end
      S_R_RD: begin
        if (sts_i.idx_ge_total) begin
          if (sts_i.region_last) begin
            cmd_o.out_ld = 1'b1; cmd_o.out_st = ST_OK;
            state_d = S_OUT; ret_d = S_IDLE;
          end else begin
            cmd_o.op = OP_R_NEXT;
          end
        end else begin
          cmd_o.op = OP_PG_RD;
          state_d  = S_R_EV;
        end
      end
      S_R_EV: begin
        cmd_o.op = OP_R_EV;
        state_d  = S_R_RD;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = ret_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

endmodule

// ===== sv/bffa_dp.sv =====
module bffa_dp import bffa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [1:0]        mode_i,
  input  logic [REG_W-1:0]  region_i,
  input  logic [OWN_W-1:0]  owner_id_i,
  input  logic [CNT_W-1:0]  page_count_i,
  input  logic              contiguous_only_i,
  input  logic [CAP_W-1:0]  result_capacity_i,
  input  logic [PG_W-1:0]   start_page_i,
  input  logic              last_extent_i,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output logic [2:0]        status_o,
  output logic [PG_W-1:0]   extent_start_o,
  output logic [CNT_W-1:0]  extent_length_o,
  output logic [CNT_W-1:0]  extent_count_o,
  output logic              last_o
);

  logic [CFG_W-1:0] cfg_q [NUM_REGIONS];
  logic [CNT_W-1:0] free_q [NUM_REGIONS];
  logic [NUM_REGIONS-1:0] clr_pend_q;
  logic [PG_W-1:0]  clr_idx_q;
  logic [REG_W-1:0] clr_r;

  logic [1:0]       mode_q;
  logic [REG_W-1:0] region_q;
  logic [OWN_W-1:0] own_q;
  logic [CNT_W-1:0] n_q;
  logic             contig_q, last_ext_q;
  logic [CAP_W-1:0] cap_q;
  logic [PG_W-1:0]  start_q;

  logic [CNT_W-1:0] idx_q, run_q, got_q, nex_q, len_q, elen_q;
  logic [PG_W-1:0]  s_q;
  logic [KW-1:0]    k_q, pcnt_q;
  logic             berr_q, in_run_q;

  logic [2:0]       ost_q;
  logic [PG_W-1:0]  oes_q;
  logic [CNT_W-1:0] oel_q, oec_q;
  logic             olast_q;

  logic             pg_en, pg_we;
  logic [ADDR_W-1:0] pg_addr;
  logic [OWN_W-1:0] pg_wdata, pg_rdata;
  logic             pr_en, pr_we, gr_en, gr_we;
  logic [EXT_W-1:0] pr_rdata, gr_rdata;

  logic [CNT_W-1:0] total, run_d, ps_len;
  logic [PG_W-1:0]  ps;
  logic [CNT_W:0]   ps_end;
  logic [CNT_W-1:0] cfg_v;
  logic [CNT_W-1:0] batch_cnt;

  assign total  = CNT_W'(cfg_q[region_q]);
  assign run_d  = (pg_rdata == '0) ? run_q + 1'b1 : '0;
  assign ps     = pr_rdata[PG_W-1:0];
  assign ps_len = pr_rdata[EXT_W-1:PG_W];
  assign ps_end = {1'b0, CNT_W'(ps)} + {1'b0, ps_len};
  assign batch_cnt = CNT_W'(pcnt_q) + CNT_W'(berr_q);

  always_comb begin
    clr_r = '0;
    for (int r = NUM_REGIONS - 1; r >= 0; r--) begin
      if (clr_pend_q[r]) begin
        clr_r = REG_W'(r);
      end
    end
  end

  // clamp a register write to 1..MAX_PAGES
  always_comb begin
    cfg_v = cfg_data_i;
    if (cfg_data_i == '0) begin
      cfg_v = CNT_W'(1);
    end else if (cfg_data_i > CNT_W'(MAX_PAGES)) begin
      cfg_v = CNT_W'(MAX_PAGES);
    end
  end

  always_comb begin
    sts_o.mode         = mode_q;
    sts_o.last_ext     = last_ext_q;
    sts_o.contig       = contig_q;
    sts_o.own_zero     = (own_q == '0);
    sts_o.a_bad        = (own_q == '0) || (n_q == '0) || (n_q > total);
    sts_o.a_nomem      = free_q[region_q] < n_q;
    sts_o.found        = (run_d == n_q);
    sts_o.scan_end     = ({1'b0, idx_q} + 1'b1) == {1'b0, total};
    sts_o.cap_zero     = (cap_q == '0);
    sts_o.rd_zero      = (pg_rdata == '0);
    sts_o.rd_own       = (pg_rdata == own_q);
    sts_o.in_run       = in_run_q;
    sts_o.g_done       = ((got_q + 1'b1) == n_q) ||
                         (({1'b0, idx_q} + 1'b1) >= {1'b0, total});
    sts_o.got_full     = (got_q == n_q);
    sts_o.nex_gt_cap   = nex_q > CNT_W'(cap_q);
    sts_o.idx_ge_total = idx_q >= total;
    sts_o.k_eq_pcnt    = (k_q == pcnt_q);
    sts_o.f_bad        = (ps_len == '0) || (ps_end > {1'b0, total});
    sts_o.len_one      = (len_q == CNT_W'(1));
    sts_o.ext_last     = (CNT_W'(k_q) + 1'b1) == nex_q;
    sts_o.region_last  = (region_q == REG_W'(NUM_REGIONS - 1));
    sts_o.berr         = berr_q;
    sts_o.clr_busy     = |clr_pend_q;
  end

  // page table port: clearing sweep while idle, else the current operation
  always_comb begin
    pg_en    = 1'b0;
    pg_we    = 1'b0;
    pg_addr  = {region_q, idx_q[PG_W-1:0]};
    pg_wdata = '0;
    if (cmd_i.idle && (|clr_pend_q)) begin
      pg_en   = 1'b1;
      pg_we   = 1'b1;
      pg_addr = {clr_r, clr_idx_q};
    end else begin
      case (cmd_i.op)
        OP_PG_RD: pg_en = 1'b1;
        OP_PG_WR_OWN: begin
          pg_en    = 1'b1;
          pg_we    = 1'b1;
          pg_wdata = own_q;
        end
        OP_P_PEV, OP_R_EV: begin
          pg_en = sts_o.rd_own;
          pg_we = sts_o.rd_own;
        end
        default: pg_en = 1'b0;
      endcase
    end
  end

  assign pr_en = (cmd_i.op == OP_PRAM_RD) || pr_we;
  assign pr_we = (cmd_i.op == OP_PEND_PUSH) && (pcnt_q < KW'(MAX_EXTENTS));
  assign gr_we = (cmd_i.op == OP_G_REC) && (nex_q < CNT_W'(cap_q));
  assign gr_en = (cmd_i.op == OP_GRAM_RD) || gr_we;

  bffa_ram #(.WIDTH(OWN_W), .DEPTH(PDEPTH)) u_page_ram (
    .clk_i   (clk_i),
    .en_i    (pg_en),
    .we_i    (pg_we),
    .addr_i  (pg_addr),
    .wdata_i (pg_wdata),
    .rdata_o (pg_rdata)
  );

  bffa_ram #(.WIDTH(EXT_W), .DEPTH(MAX_EXTENTS)) u_pend_ram (
    .clk_i   (clk_i),
    .en_i    (pr_en),
    .we_i    (pr_we),
    .addr_i  (pr_we ? pcnt_q[EXT_AW-1:0] : k_q[EXT_AW-1:0]),
    .wdata_i ({n_q, start_q}),
    .rdata_o (pr_rdata)
  );

  bffa_ram #(.WIDTH(EXT_W), .DEPTH(MAX_EXTENTS)) u_gath_ram (
    .clk_i   (clk_i),
    .en_i    (gr_en),
    .we_i    (gr_we),
    .addr_i  (gr_we ? nex_q[EXT_AW-1:0] : k_q[EXT_AW-1:0]),
    .wdata_i ({len_q, s_q}),
    .rdata_o (gr_rdata)
  );

  // control state: region sizes, free counts, clearing sweep, batch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_REGIONS; r++) begin
        cfg_q[r]  <= PAGES_RST[r];
        free_q[r] <= CNT_W'(PAGES_RST[r]);
      end
      clr_pend_q <= '1;
      clr_idx_q  <= '0;
      pcnt_q     <= '0;
      berr_q     <= 1'b0;
    end else if (cfg_we_i && (int'(cfg_idx_i) < NUM_REGIONS)) begin
      // restart the sweep on every write so that no region is left half cleared
      cfg_q[cfg_idx_i]      <= cfg_v;
      free_q[cfg_idx_i]     <= cfg_v;
      clr_pend_q[cfg_idx_i] <= 1'b1;
      clr_idx_q             <= '0;
    end else begin
      if (cmd_i.idle && (|clr_pend_q)) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (&clr_idx_q) begin
          clr_pend_q[clr_r] <= 1'b0;
        end
      end
      case (cmd_i.op)
        OP_PG_WR_OWN: begin
          if (sts_o.len_one) begin
            free_q[region_q] <= free_q[region_q] - elen_q;
          end
        end
        OP_P_PEV, OP_R_EV: begin
          if (sts_o.rd_own) begin
            free_q[region_q] <= free_q[region_q] + 1'b1;
          end
        end
        OP_PEND_PUSH: begin
          if (pcnt_q < KW'(MAX_EXTENTS)) begin
            pcnt_q <= pcnt_q + 1'b1;
          end else begin
            berr_q <= 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (cmd_i.batch_clr) begin
        pcnt_q <= '0;
        berr_q <= 1'b0;
      end
    end
  end

  // datapath working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LATCH: begin
        mode_q     <= mode_i;
        region_q   <= region_i;
        own_q      <= owner_id_i;
        n_q        <= page_count_i;
        contig_q   <= contiguous_only_i;
        cap_q      <= (result_capacity_i > CAP_W'(MAX_EXTENTS)) ?
                      CAP_W'(MAX_EXTENTS) : result_capacity_i;
        start_q    <= start_page_i;
        last_ext_q <= last_extent_i;
      end
      OP_SCAN_INIT: begin
        idx_q    <= '0;
        run_q    <= '0;
        got_q    <= '0;
        nex_q    <= '0;
        in_run_q <= 1'b0;
      end
      OP_A_EV: begin
        if (sts_o.found) begin
          s_q    <= PG_W'(idx_q + 1'b1 - n_q);
          idx_q  <= idx_q + 1'b1 - n_q;
          len_q  <= n_q;
          elen_q <= n_q;
          nex_q  <= CNT_W'(1);
          k_q    <= '0;
        end else begin
          idx_q <= idx_q + 1'b1;
          run_q <= run_d;
        end
      end
      OP_G_EV: begin
        if (pg_rdata == '0) begin
          if (!in_run_q) begin
            s_q      <= idx_q[PG_W-1:0];
            len_q    <= CNT_W'(1);
            in_run_q <= 1'b1;
          end else begin
            len_q <= len_q + 1'b1;
          end
          got_q <= got_q + 1'b1;
          idx_q <= idx_q + 1'b1;
        end else if (!in_run_q) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      OP_G_REC: begin
        nex_q    <= nex_q + 1'b1;
        in_run_q <= 1'b0;
      end
      OP_C_LD: begin
        s_q    <= gr_rdata[PG_W-1:0];
        idx_q  <= CNT_W'(gr_rdata[PG_W-1:0]);
        len_q  <= gr_rdata[EXT_W-1:PG_W];
        elen_q <= gr_rdata[EXT_W-1:PG_W];
      end
      OP_PG_WR_OWN: begin
        idx_q <= idx_q + 1'b1;
        len_q <= len_q - 1'b1;
      end
      OP_K_INC:  k_q <= k_q + 1'b1;
      OP_K_ZERO: k_q <= '0;
      OP_F_LD: begin
        idx_q <= CNT_W'(ps);
        len_q <= ps_len;
      end
      OP_F_PEV, OP_P_PEV: begin
        idx_q <= idx_q + 1'b1;
        len_q <= len_q - 1'b1;
        if (sts_o.len_one) begin
          k_q <= k_q + 1'b1;
        end
      end
      OP_R_INIT: begin
        region_q <= '0;
        idx_q    <= '0;
      end
      OP_R_NEXT: begin
        region_q <= region_q + 1'b1;
        idx_q    <= '0;
      end
      OP_R_EV: idx_q <= idx_q + 1'b1;
      default: begin
      end
    endcase

    if (cmd_i.out_ld) begin
      ost_q   <= cmd_i.out_st;
      oes_q   <= cmd_i.ext ? s_q : '0;
      oel_q   <= cmd_i.ext ? elen_q : '0;
      olast_q <= cmd_i.ext ? sts_o.ext_last : 1'b1;
      case (cmd_i.ec_sel)
        EC_ONE:   oec_q <= CNT_W'(1);
        EC_NEX:   oec_q <= nex_q;
        EC_BATCH: oec_q <= batch_cnt;
        default:  oec_q <= '0;
      endcase
    end
  end

  assign status_o        = ost_q;
  assign extent_start_o  = oes_q;
  assign extent_length_o = oel_q;
  assign extent_count_o  = oec_q;
  assign last_o          = olast_q;

endmodule

// ===== sv/bitmap_first_fit_page_allocator_core.sv =====
// First-fit page allocator over one owner byte per page and region (owner 0 is
// free), held in a single-port page table RAM that is touched one page per
// access. Allocate scans for the lowest contiguous run, falls back to
// gathering free runs front to back when allowed, then writes the owner into
// each granted page extent by extent and presents one result per extent.
// Free collects a batch of extents, one per transfer, and on the final one
// checks every page before releasing them. Reclaim walks every configured
// page of both regions. The page table port sets the time a request takes.
// After reset the block clears the whole table, one page a cycle while no
// register write restarts the sweep, and after a write of a region size it
// clears that region; input is stalled meanwhile, register writes are
// still taken. Each result is held in an output register until its
// transfer completes.
module bitmap_first_fit_page_allocator_core import bffa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        mode_i,
  input  logic [REG_W-1:0]  region_i,
  input  logic [OWN_W-1:0]  owner_id_i,
  input  logic [CNT_W-1:0]  page_count_i,
  input  logic              contiguous_only_i,
  input  logic [CAP_W-1:0]  result_capacity_i,
  input  logic [PG_W-1:0]   start_page_i,
  input  logic              last_extent_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic [PG_W-1:0]   extent_start_o,
  output logic [CNT_W-1:0]  extent_length_o,
  output logic [CNT_W-1:0]  extent_count_o,
  output logic              last_o,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // stall input whenever the sequencer is busy or the table is being cleared
  assign in_stall_o = !in_ready;

  bffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid_o)
  );

  bffa_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .mode_i            (mode_i),
    .region_i          (region_i),
    .owner_id_i        (owner_id_i),
    .page_count_i      (page_count_i),
    .contiguous_only_i (contiguous_only_i),
    .result_capacity_i (result_capacity_i),
    .start_page_i      (start_page_i),
    .last_extent_i     (last_extent_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .status_o          (status_o),
    .extent_start_o    (extent_start_o),
    .extent_length_o   (extent_length_o),
    .extent_count_o    (extent_count_o),
    .last_o            (last_o)
  );

endmodule
